// ----- rtl/core/mts_pkg.sv -----
// shared types and constants for the min tracking stack
package mts_pkg;

  // default sizes, handed to the top level parameters
  localparam int unsigned DepthDef     = 128;
  localparam int unsigned WordWidthDef = 32;

  // fixed field widths on the stream ports
  localparam int unsigned DataW      = 32;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned CountW     = 8;
  localparam int unsigned OutFieldsW = StatusW + DataW + DataW + 1 + CountW;
  localparam int unsigned OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

  // values reported when the stack holds nothing
  localparam logic [DataW-1:0] EmptyTop = DataW'(-2);
  localparam logic [DataW-1:0] EmptyMin = '0;

  // operation codes
  typedef enum logic [CmdW-1:0] {
    CMD_QUERY = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_POP   = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // shift control seen by every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

// ----- rtl/core/mts_cell.sv -----
// one stack slot: entry word and running minimum, shifted with its neighbors
module mts_cell
  import mts_pkg::*;
#(
  parameter int unsigned WordWidth = WordWidthDef
) (
  input  logic                        clk_i,
  input  shift_t                      shift_i,
  input  logic signed [WordWidth-1:0] up_val_i,  // neighbor nearer the top
  input  logic signed [WordWidth-1:0] up_min_i,
  input  logic signed [WordWidth-1:0] dn_val_i,  // neighbor nearer the bottom
  input  logic signed [WordWidth-1:0] dn_min_i,
  output logic signed [WordWidth-1:0] val_o,
  output logic signed [WordWidth-1:0] min_o
);

  logic signed [WordWidth-1:0] val_q, val_d;
  logic signed [WordWidth-1:0] min_q, min_d;

  // push moves entries away from the top, pop moves them toward it
  always_comb begin
    val_d = val_q;
    min_d = min_q;
    if (shift_i.push) begin
      val_d = up_val_i;
      min_d = up_min_i;
    end else if (shift_i.pop) begin
      val_d = dn_val_i;
      min_d = dn_min_i;
    end
  end

  // payload only, contents are meaningless until filled
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    min_q <= min_d;
  end

  assign val_o = val_q;
  assign min_o = min_q;

endmodule

// ----- rtl/core/min_tracking_stack_top.sv -----
// top level of the min tracking stack: control, cell chain and result register
//
//  channel  | dir | handshake                     | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser: cmd, tdata: push_value
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: status, top, min, empty, count
//
// one transaction per cycle while m_axis takes each result: a push or pop that succeeds
// shifts the cell chain, and each result is registered, available on m_axis the next cycle
// the top entry always sits in cell 0, so top and min come from fixed places
// reset clears the fill count and the result valid; cell contents need no clearing
// a stalled result holds s_axis_tready low until it is taken, unless taken that cycle
module min_tracking_stack_top
  import mts_pkg::*;
#(
  parameter int unsigned DEPTH      = DepthDef,
  parameter int unsigned WORD_WIDTH = WordWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DataW-1:0]     s_axis_tdata,   // [31:0] push_value
  input  logic [CmdW-1:0]      s_axis_tuser,   // [1:0] cmd
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [1:0] status, [33:2] top_value, [65:34] min_value, [66] is_empty,
  // [74:67] entry_count, upper bits zero
  output logic [OutTdataW-1:0] m_axis_tdata
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
  localparam logic [CntW-1:0] CntOne   = CntW'(1);

  logic signed [WORD_WIDTH-1:0] cell_val [DEPTH];
  logic signed [WORD_WIDTH-1:0] cell_min [DEPTH];

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic [OutTdataW-1:0] out_data_q, out_data_d;

  logic                         in_fire;
  logic                         is_full;
  logic                         is_zero;
  logic signed [WORD_WIDTH-1:0] push_word;
  logic signed [WORD_WIDTH-1:0] push_min;
  logic signed [WORD_WIDTH-1:0] top_word;
  logic signed [WORD_WIDTH-1:0] min_word;
  logic [DataW-1:0]             top_ext;
  logic [DataW-1:0]             min_ext;
  logic [DataW-1:0]             top_out;
  logic [DataW-1:0]             min_out;
  logic [CountW-1:0]            count_out;
  status_e                      status;
  shift_t                       shift;

  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign is_full       = (cnt_q == DepthCnt);
  assign is_zero       = (cnt_q == '0);

  // fit the pushed word to the stored width
  generate
    if (WORD_WIDTH <= DataW) begin : g_push_narrow
      assign push_word = s_axis_tdata[WORD_WIDTH-1:0];
    end else begin : g_push_wide
      assign push_word = {{(WORD_WIDTH-DataW){s_axis_tdata[DataW-1]}}, s_axis_tdata};
    end
  endgenerate

  // running minimum for the entry being pushed
  assign push_min = (is_zero || (push_word < cell_min[0])) ? push_word : cell_min[0];

  // command decode: chain shift, status, next count and new top entry
  always_comb begin
    shift    = '0;
    status   = ST_OK;
    cnt_d    = cnt_q;
    top_word = cell_val[0];
    min_word = cell_min[0];
    case (cmd_e'(s_axis_tuser))
      CMD_PUSH: begin
        if (is_full) begin
          status = ST_OVERFLOW;
        end else begin
          shift.push = in_fire;
          cnt_d      = cnt_q + CntOne;
          top_word   = push_word;
          min_word   = push_min;
        end
      end
      CMD_POP: begin
        if (is_zero) begin
          status = ST_UNDERFLOW;
        end else begin
          shift.pop = in_fire;
          cnt_d     = cnt_q - CntOne;
          top_word  = cell_val[1];
          min_word  = cell_min[1];
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // bring stored words back to the 32 bit result fields
  generate
    if (WORD_WIDTH >= DataW) begin : g_out_wide
      assign top_ext = top_word[DataW-1:0];
      assign min_ext = min_word[DataW-1:0];
    end else begin : g_out_narrow
      assign top_ext = {{(DataW-WORD_WIDTH){top_word[WORD_WIDTH-1]}}, top_word};
      assign min_ext = {{(DataW-WORD_WIDTH){min_word[WORD_WIDTH-1]}}, min_word};
    end
    if (CntW >= CountW) begin : g_cnt_wide
      assign count_out = cnt_d[CountW-1:0];
    end else begin : g_cnt_narrow
      assign count_out = {{(CountW-CntW){1'b0}}, cnt_d};
    end
  endgenerate

  assign top_out = (cnt_d == '0) ? EmptyTop : top_ext;
  assign min_out = (cnt_d == '0) ? EmptyMin : min_ext;

  // result register: loads on each accepted transaction
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
      out_data_d  = OutTdataW'({count_out, (cnt_d == '0), min_out, top_out, status});
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_q <= cnt_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // chain of cells, cell 0 holds the top of the stack
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [WORD_WIDTH-1:0] up_val, up_min, dn_val, dn_min;
      if (i == 0) begin : g_head
        assign up_val = push_word;
        assign up_min = push_min;
      end else begin : g_body_up
        assign up_val = cell_val[i-1];
        assign up_min = cell_min[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
        assign dn_val = cell_val[i];
        assign dn_min = cell_min[i];
      end else begin : g_body_dn
        assign dn_val = cell_val[i+1];
        assign dn_min = cell_min[i+1];
      end
      mts_cell #(
        .WordWidth(WORD_WIDTH)
      ) u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .up_val_i(up_val),
        .up_min_i(up_min),
        .dn_val_i(dn_val),
        .dn_min_i(dn_min),
        .val_o   (cell_val[i]),
        .min_o   (cell_min[i])
      );
    end
  endgenerate

endmodule
